// ===== src/jsu_pkg.sv =====
// jsu_pkg: shared types and constants of the json string unescaper
// no dependencies; used by every other file of the block but jsu_stream_if
package jsu_pkg;

    // special bytes of a json string body
    localparam logic [7:0] C_QUOTE     = 8'h22;
    localparam logic [7:0] C_BACKSLASH = 8'h5C;
    localparam logic [7:0] C_SLASH     = 8'h2F;
    localparam logic [7:0] C_LOWER_B   = 8'h62;
    localparam logic [7:0] C_LOWER_F   = 8'h66;
    localparam logic [7:0] C_LOWER_N   = 8'h6E;
    localparam logic [7:0] C_LOWER_R   = 8'h72;
    localparam logic [7:0] C_LOWER_T   = 8'h74;
    localparam logic [7:0] C_LOWER_U   = 8'h75;
    localparam logic [7:0] C_NUL       = 8'h00;

    // control characters produced by the short escapes
    localparam logic [7:0] C_BS  = 8'h08;
    localparam logic [7:0] C_FF  = 8'h0C;
    localparam logic [7:0] C_LF  = 8'h0A;
    localparam logic [7:0] C_CR  = 8'h0D;
    localparam logic [7:0] C_TAB = 8'h09;

    // utf-8 encoding
    localparam logic [7:0]  C_LEAD2    = 8'hC0;
    localparam logic [7:0]  C_LEAD3    = 8'hE0;
    localparam logic [7:0]  C_CONT     = 8'h80;
    localparam logic [7:0]  C_CONT_MSK = 8'h3F;
    localparam logic [15:0] C_ONE_MAX  = 16'h0080;
    localparam logic [15:0] C_TWO_MAX  = 16'h0800;

    localparam int unsigned MAX_RESULTS = 3;

    typedef enum logic [2:0] {
        KIND_DATA    = 3'd0,
        KIND_END     = 3'd1,
        KIND_BAD_ESC = 3'd2,
        KIND_BAD_HEX = 3'd3,
        KIND_UNTERM  = 3'd4
    } t_kind;

    typedef struct packed {
        logic [7:0] out_byte;
        t_kind      kind;
        logic       last;
    } t_result;

    // all results caused by one input item
    typedef struct packed {
        t_result [MAX_RESULTS-1:0] res;
        logic [1:0]                cnt;
    } t_group;

endpackage

// ===== src/jsu_stream_if.sv =====
// jsu_in_if / jsu_out_if: valid/ready channels of the json string unescaper
// no dependencies
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] kind;
    logic       last;

    modport source (output valid, output out_byte, output kind, output last, input ready);
    modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface

// ===== src/jsu_decode.sv =====
// jsu_decode: escape state and per-item decode into a group of up to three results
// depends on jsu_pkg
module jsu_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    output jsu_pkg::t_group  o_grp
);

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESCAPE = 2'd1,
        MODE_HEX    = 2'd2
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [1:0]  r_digits, n_digits;
    logic [11:0] r_cp, n_cp;

    // bit 4 flags a valid hex digit, bits 3:0 its value
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            v = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            v = {1'b1, 4'(b - 8'h37)};
        end
        return v;
    endfunction

    logic [4:0]  w_hex;
    logic [15:0] w_cp;

    always_comb begin
        w_hex = hex_value(i_byte);
        w_cp  = {r_cp, w_hex[3:0]};

        n_mode   = r_mode;
        n_digits = r_digits;
        n_cp     = r_cp;
        o_grp.cnt = 2'd0;
        for (int i = 0; i < jsu_pkg::MAX_RESULTS; i++) begin
            o_grp.res[i] = '{out_byte: jsu_pkg::C_NUL, kind: jsu_pkg::KIND_DATA, last: 1'b0};
        end
        // single-result default: entry 0 is last
        o_grp.res[0].last = 1'b1;

        if (i_byte == jsu_pkg::C_NUL) begin
            n_mode = MODE_NORMAL; n_digits = 2'd0; n_cp = 12'd0;
            o_grp.cnt = 2'd1;
            o_grp.res[0].kind = jsu_pkg::KIND_UNTERM;
        end else begin
            unique case (r_mode)
                MODE_ESCAPE: begin
                    n_mode = MODE_NORMAL; n_digits = 2'd0; n_cp = 12'd0;
                    o_grp.cnt = 2'd1;
                    unique case (i_byte)
                        jsu_pkg::C_QUOTE, jsu_pkg::C_BACKSLASH, jsu_pkg::C_SLASH: begin
                            o_grp.res[0].out_byte = i_byte;
                        end
                        jsu_pkg::C_LOWER_B: o_grp.res[0].out_byte = jsu_pkg::C_BS;
                        jsu_pkg::C_LOWER_F: o_grp.res[0].out_byte = jsu_pkg::C_FF;
                        jsu_pkg::C_LOWER_N: o_grp.res[0].out_byte = jsu_pkg::C_LF;
                        jsu_pkg::C_LOWER_R: o_grp.res[0].out_byte = jsu_pkg::C_CR;
                        jsu_pkg::C_LOWER_T: o_grp.res[0].out_byte = jsu_pkg::C_TAB;
                        jsu_pkg::C_LOWER_U: begin
                            n_mode = MODE_HEX;
                            o_grp.cnt = 2'd0;
                        end
                        default: o_grp.res[0].kind = jsu_pkg::KIND_BAD_ESC;
                    endcase
                end
                MODE_HEX: begin
                    if (!w_hex[4]) begin
                        n_mode = MODE_NORMAL; n_digits = 2'd0; n_cp = 12'd0;
                        o_grp.cnt = 2'd1;
                        o_grp.res[0].kind = jsu_pkg::KIND_BAD_HEX;
                    end else if (r_digits == 2'd3) begin
                        n_mode = MODE_NORMAL; n_digits = 2'd0; n_cp = 12'd0;
                        if (w_cp < jsu_pkg::C_ONE_MAX) begin
                            o_grp.cnt = 2'd1;
                            o_grp.res[0].out_byte = w_cp[7:0];
                        end else if (w_cp < jsu_pkg::C_TWO_MAX) begin
                            o_grp.cnt = 2'd2;
                            o_grp.res[0].last = 1'b0;
                            o_grp.res[0].out_byte = jsu_pkg::C_LEAD2 | {3'd0, w_cp[10:6]};
                            o_grp.res[1].out_byte =
                                jsu_pkg::C_CONT | (jsu_pkg::C_CONT_MSK & {2'd0, w_cp[5:0]});
                            o_grp.res[1].last = 1'b1;
                        end else begin
                            o_grp.cnt = 2'd3;
                            o_grp.res[0].last = 1'b0;
                            o_grp.res[0].out_byte = jsu_pkg::C_LEAD3 | {4'd0, w_cp[15:12]};
                            o_grp.res[1].out_byte =
                                jsu_pkg::C_CONT | (jsu_pkg::C_CONT_MSK & {2'd0, w_cp[11:6]});
                            o_grp.res[2].out_byte =
                                jsu_pkg::C_CONT | (jsu_pkg::C_CONT_MSK & {2'd0, w_cp[5:0]});
                            o_grp.res[2].last = 1'b1;
                        end
                    end else begin
                        n_digits = r_digits + 2'd1;
                        n_cp     = w_cp[11:0];
                    end
                end
                default: begin
                    // normal mode, also the unused mode code
                    n_mode = MODE_NORMAL; n_digits = 2'd0; n_cp = 12'd0;
                    if (i_byte == jsu_pkg::C_BACKSLASH) begin
                        n_mode = MODE_ESCAPE;
                    end else if (i_byte == jsu_pkg::C_QUOTE) begin
                        o_grp.cnt = 2'd1;
                        o_grp.res[0].kind = jsu_pkg::KIND_END;
                    end else begin
                        o_grp.cnt = 2'd1;
                        o_grp.res[0].out_byte = i_byte;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_NORMAL;
            r_digits <= 2'd0;
            r_cp     <= 12'd0;
        end else if (i_step) begin
            r_mode   <= n_mode;
            r_digits <= n_digits;
            r_cp     <= n_cp;
        end
    end

endmodule

// ===== src/jsu_emit.sv =====
// jsu_emit: result register holding one group, sent one item per handshake
// depends on jsu_pkg and jsu_out_if
module jsu_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  jsu_pkg::t_group i_grp,
    output logic            o_take,
    jsu_out_if.source       o_out
);

    jsu_pkg::t_result [jsu_pkg::MAX_RESULTS-1:0] r_res;
    logic [1:0] r_cnt;
    logic [1:0] r_pos;
    logic       w_free;
    logic       w_load;
    logic       w_send;

    always_comb begin
        w_send = o_out.valid && o_out.ready;
        // register is empty or empties in this cycle
        w_free = (r_cnt == 2'd0) || (r_cnt == 2'd1 && o_out.ready);
        // a group without results never has to wait
        o_take = (i_grp.cnt == 2'd0) || w_free;
        w_load = i_valid && w_free && (i_grp.cnt != 2'd0);
    end

    assign o_out.valid    = (r_cnt != 2'd0);
    assign o_out.out_byte = r_res[r_pos].out_byte;
    assign o_out.kind     = r_res[r_pos].kind;
    assign o_out.last     = r_res[r_pos].last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_pos <= 2'd0;
        end else if (w_load) begin
            r_cnt <= i_grp.cnt;
            r_pos <= 2'd0;
        end else if (w_send) begin
            r_cnt <= r_cnt - 2'd1;
            r_pos <= r_pos + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res <= i_grp.res;
        end
    end

endmodule

// ===== src/json_string_unescaper.sv =====
// json_string_unescaper: top level of the json string body unescaper
// depends on jsu_pkg, jsu_stream_if, jsu_decode and jsu_emit
//
// usage
//   i_in  carries the bytes of a json string body, one item per byte, starting
//         after the opening quote; a zero byte marks the end of input
//   o_out carries result items: decoded data bytes, a string end marker, or an
//         error code; last is set on the final item caused by an input byte
//   plain bytes and short escapes give one item, a \u escape gives one to three
//   utf-8 bytes on its fourth hex digit, a backslash, the u and the first three
//   hex digits give none
// timing
//   an input byte is registered on acceptance, and its group is loaded into the
//   result register at the edge at which that register frees; its first item
//   then shows on o_out from the result register
//   one byte per cycle is taken while each gives at most one item and o_out does
//   not stall; a byte that gives more items holds the next one back while the
//   result register sends them out one by one
// reset and stall
//   synchronous reset returns to normal mode and drops the input and result
//   registers; when o_out stalls, bytes that give no item still flow through
//   and the input side stops once the input register holds a byte with results
module json_string_unescaper (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jsu_in_if.sink    i_in,
    jsu_out_if.source o_out
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    jsu_pkg::t_group w_grp;
    logic            w_take;
    logic            w_step;

    // the input register frees when its group moves into the result register or has no results
    assign i_in.ready = !r_in_valid || w_take;
    assign w_step     = r_in_valid && w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
        end
    end

    // mode tracking and decode of the registered byte
    jsu_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_byte  (r_in_byte),
        .o_grp   (w_grp)
    );

    // result register and item sequencing
    jsu_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_grp   (w_grp),
        .o_take  (w_take),
        .o_out   (o_out)
    );

`ifndef SYNTHESIS
    // an item that is not last is always followed by another item of its group
    a_group_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && !o_out.last |=> o_out.valid)
        else $error("group ended before its last item");

    // a held input byte is neither lost nor changed
    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_take |=> r_in_valid && $stable(r_in_byte))
        else $error("pending input byte lost");

    // status items are single and carry a zero byte
    a_status_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.kind != jsu_pkg::KIND_DATA)
        |-> o_out.last && (o_out.out_byte == jsu_pkg::C_NUL))
        else $error("status item malformed");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking testbench of the json string unescaper
// depends on jsu_pkg, jsu_stream_if and json_string_unescaper
module tb_top;
    import jsu_pkg::*;

    localparam int unsigned CYCLE_LIMIT      = 200000;
    localparam int unsigned LONG_HOLD_CYCLES = 400;
    localparam int unsigned DRAIN_CYCLES     = 10;
    localparam int unsigned MAX_PRINTED      = 30;

    // decoder modes of the predictor
    typedef enum logic [1:0] {
        DEC_NORMAL = 2'd0,
        DEC_ESCAPE = 2'd1,
        DEC_HEX    = 2'd2
    } t_dec_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    jsu_in_if  in_if ();
    jsu_out_if out_if ();

    json_string_unescaper u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #1 i_clk = ~i_clk;

    // predictor state, mirrors the block's mode, digit count and code point
    t_dec_mode   dec_mode;
    logic [1:0]  hex_count;
    logic [15:0] cp_acc;

    // decoded items still owed by the block, oldest first
    t_result     pending_results[$];

    int unsigned error_count = 0;
    int unsigned bytes_sent  = 0;
    int unsigned cycle_count = 0;

    // idling knobs, in percent
    int unsigned in_idle_pct   = 0;
    int unsigned out_stall_pct = 0;

    // long output hold, requested by the test, counted by the receiver
    int unsigned hold_req_count = 0;
    int unsigned hold_ack_count = 0;
    int unsigned hold_left      = 0;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic int digit_value(input logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b - "0");
        if (b >= "a" && b <= "f") return int'(b - "a") + 10;
        if (b >= "A" && b <= "F") return int'(b - "A") + 10;
        return -1;
    endfunction

    function automatic void reset_decoder();
        dec_mode  = DEC_NORMAL;
        hex_count = 2'd0;
        cp_acc    = 16'h0000;
    endfunction

    function automatic void expect_item(input logic [7:0] b, input t_kind k, input logic l);
        t_result r;
        r.out_byte = b;
        r.kind     = k;
        r.last     = l;
        pending_results.insert(pending_results.size(), r);
    endfunction

    // utf-8 encoding of a 16-bit code point, one to three bytes
    function automatic void expect_code_point(input logic [15:0] cp);
        if (cp < C_ONE_MAX) begin
            expect_item(cp[7:0], KIND_DATA, 1'b1);
        end else if (cp < C_TWO_MAX) begin
            expect_item(C_LEAD2 | {3'b000, cp[10:6]}, KIND_DATA, 1'b0);
            expect_item(C_CONT | (cp[7:0] & C_CONT_MSK), KIND_DATA, 1'b1);
        end else begin
            expect_item(C_LEAD3 | {4'h0, cp[15:12]}, KIND_DATA, 1'b0);
            expect_item(C_CONT | {2'b00, cp[11:6]}, KIND_DATA, 1'b0);
            expect_item(C_CONT | (cp[7:0] & C_CONT_MSK), KIND_DATA, 1'b1);
        end
    endfunction

    // one accepted input byte: advance the predictor and queue its items
    function automatic void unescape_byte(input logic [7:0] b);
        int nib;
        nib = digit_value(b);
        if (b == C_NUL) begin
            // end of input wins in every mode
            reset_decoder();
            expect_item(8'h00, KIND_UNTERM, 1'b1);
        end else if (dec_mode == DEC_ESCAPE) begin
            reset_decoder();
            case (b)
                C_QUOTE, C_BACKSLASH, C_SLASH: expect_item(b, KIND_DATA, 1'b1);
                C_LOWER_B: expect_item(C_BS, KIND_DATA, 1'b1);
                C_LOWER_F: expect_item(C_FF, KIND_DATA, 1'b1);
                C_LOWER_N: expect_item(C_LF, KIND_DATA, 1'b1);
                C_LOWER_R: expect_item(C_CR, KIND_DATA, 1'b1);
                C_LOWER_T: expect_item(C_TAB, KIND_DATA, 1'b1);
                C_LOWER_U: dec_mode = DEC_HEX;
                default:   expect_item(8'h00, KIND_BAD_ESC, 1'b1);
            endcase
        end else if (dec_mode == DEC_HEX) begin
            if (nib < 0) begin
                reset_decoder();
                expect_item(8'h00, KIND_BAD_HEX, 1'b1);
            end else begin
                cp_acc = {cp_acc[11:0], nib[3:0]};
                if (hex_count == 2'd3) begin
                    expect_code_point(cp_acc);
                    reset_decoder();
                end else begin
                    hex_count = hex_count + 2'd1;
                end
            end
        end else begin
            // normal mode
            reset_decoder();
            if (b == C_QUOTE) begin
                expect_item(8'h00, KIND_END, 1'b1);
            end else if (b == C_BACKSLASH) begin
                dec_mode = DEC_ESCAPE;
            end else begin
                expect_item(b, KIND_DATA, 1'b1);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // ascii hex digit, letters in a random case
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return "0" + {4'h0, n};
        return ($urandom_range(1) ? "a" : "A") + {4'h0, n} - 8'd10;
    endfunction

    // second byte of the short escape with the given index
    function automatic logic [7:0] short_escape(input int unsigned idx);
        case (idx)
            0:       return C_QUOTE;
            1:       return C_BACKSLASH;
            2:       return C_SLASH;
            3:       return C_LOWER_B;
            4:       return C_LOWER_F;
            5:       return C_LOWER_N;
            6:       return C_LOWER_R;
            default: return C_LOWER_T;
        endcase
    endfunction

    // offer one byte, with a random gap before it, and wait for acceptance;
    // entered and left right after a rising edge
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < in_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.in_byte <= b;
        do @(posedge i_clk); while (!in_if.ready);
        unescape_byte(b);
        bytes_sent++;
    endtask

    task automatic send_u_escape(input logic [15:0] cp);
        send_byte(C_BACKSLASH);
        send_byte(C_LOWER_U);
        send_byte(hex_char(cp[15:12]));
        send_byte(hex_char(cp[11:8]));
        send_byte(hex_char(cp[7:4]));
        send_byte(hex_char(cp[3:0]));
    endtask

    // code point spread over the one, two and three byte ranges and their edges
    function automatic logic [15:0] pick_code_point();
        case ($urandom_range(4))
            0: return 16'($urandom_range(16'h007F, 16'h0000));
            1: return 16'($urandom_range(16'h07FF, 16'h0080));
            2: return 16'($urandom_range(16'hFFFF, 16'h0800));
            3: return 16'($urandom_range(16'hFFFF, 16'h0000));
            default: begin
                case ($urandom_range(5))
                    0:       return 16'h0000;
                    1:       return 16'h007F;
                    2:       return 16'h0080;
                    3:       return 16'h07FF;
                    4:       return 16'h0800;
                    default: return 16'hFFFF;
                endcase
            end
        endcase
    endfunction

    // one random piece of a string body; mostly well-formed
    task automatic send_random_token();
        int unsigned pick;
        int unsigned n;
        logic [7:0]  b;
        pick = $urandom_range(99);
        if (pick < 40) begin
            send_byte(8'($urandom_range(255, 1)));
        end else if (pick < 48) begin
            send_byte(C_QUOTE);
        end else if (pick < 63) begin
            send_byte(C_BACKSLASH);
            send_byte(short_escape($urandom_range(7)));
        end else if (pick < 85) begin
            send_u_escape(pick_code_point());
        end else if (pick < 89) begin
            // escape with an arbitrary second byte, mostly unknown
            send_byte(C_BACKSLASH);
            send_byte(8'($urandom_range(255, 1)));
        end else if (pick < 94) begin
            // \u escape broken by a non-hex byte after 0 to 3 digits
            send_byte(C_BACKSLASH);
            send_byte(C_LOWER_U);
            n = $urandom_range(3);
            repeat (n) send_byte(hex_char(4'($urandom_range(15))));
            do b = 8'($urandom_range(255, 1)); while (digit_value(b) >= 0);
            send_byte(b);
        end else begin
            // zero byte, possibly inside an escape
            n = $urandom_range(5);
            if (n >= 1) send_byte(C_BACKSLASH);
            if (n >= 2) send_byte(C_LOWER_U);
            if (n >= 3) repeat (n - 2) send_byte(hex_char(4'($urandom_range(15))));
            send_byte(C_NUL);
        end
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic test_directed_cases();
        logic [7:0] bad_hex [6];
        bad_hex = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};
        in_idle_pct   = 0;
        out_stall_pct = 0;
        // plain bytes at the edges of the range
        send_byte(8'h01);
        send_byte(8'h7F);
        send_byte(8'h80);
        send_byte(8'hFF);
        // every short escape, then the closing quote
        for (int unsigned i = 0; i < 8; i++) begin
            send_byte(C_BACKSLASH);
            send_byte(short_escape(i));
        end
        send_byte(C_QUOTE);
        // unknown escapes
        send_byte(C_BACKSLASH);
        send_byte("x");
        send_byte(C_BACKSLASH);
        send_byte(8'hFF);
        // \u at the utf-8 range boundaries, escaped zero among them
        send_u_escape(16'h0000);
        send_u_escape(16'h007F);
        send_u_escape(16'h0080);
        send_u_escape(16'h07FF);
        send_u_escape(16'h0800);
        send_u_escape(16'hFFFF);
        // hex digit extremes in both cases
        send_byte(C_BACKSLASH);
        send_byte(C_LOWER_U);
        send_byte("A");
        send_byte("f");
        send_byte("0");
        send_byte("9");
        send_byte(C_BACKSLASH);
        send_byte(C_LOWER_U);
        send_byte("F");
        send_byte("a");
        send_byte("9");
        send_byte("0");
        // bytes just outside the hex digit ranges, the last one as fourth digit
        foreach (bad_hex[i]) begin
            send_byte(C_BACKSLASH);
            send_byte(C_LOWER_U);
            if (i == 5) begin
                send_byte("1");
                send_byte("2");
                send_byte("3");
            end
            send_byte(bad_hex[i]);
        end
        // zero byte in normal, escape and hex mode
        send_byte(C_NUL);
        send_byte(C_BACKSLASH);
        send_byte(C_NUL);
        send_byte(C_BACKSLASH);
        send_byte(C_LOWER_U);
        send_byte(C_NUL);
        send_byte(C_BACKSLASH);
        send_byte(C_LOWER_U);
        send_byte("1");
        send_byte("2");
        send_byte("3");
        send_byte(C_NUL);
    endtask

    // random body text under each idling pattern
    task automatic test_random_traffic();
        int unsigned target;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 61; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 61; end
                default: begin in_idle_pct = 19; out_stall_pct = 19; end
            endcase
            target = bytes_sent + 50;
            while (bytes_sent < target) send_random_token();
        end
    endtask

    // the receiver holds off for a long stretch while bytes keep coming,
    // so the block fills up and stops taking input
    task automatic test_output_backpressure();
        in_idle_pct    = 0;
        out_stall_pct  = 0;
        hold_req_count <= hold_req_count + 1;
        repeat (6) begin
            send_byte(8'($urandom_range(255, 1)));
            send_u_escape(16'($urandom_range(16'hFFFF, 16'h0800)));
            send_byte(C_QUOTE);
        end
    endtask

    // ------------------------------------------------------------------
    // receiver and checker
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_req_count != hold_ack_count) begin
            hold_ack_count <= hold_req_count;
            hold_left      <= LONG_HOLD_CYCLES;
            out_if.ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (error_count < MAX_PRINTED)
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected item, out_byte", out_if.out_byte, 8'h00);
            end else begin
                want = pending_results.pop_front();
                if (out_if.out_byte !== want.out_byte)
                    report_mismatch("out_byte", out_if.out_byte, want.out_byte);
                if (out_if.kind !== want.kind)
                    report_mismatch("kind", {5'd0, out_if.kind}, {5'd0, want.kind});
                if (out_if.last !== want.last)
                    report_mismatch("last", {7'd0, out_if.last}, {7'd0, want.last});
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.in_byte = 8'h00;
        reset_decoder();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_random_traffic();
        test_output_backpressure();

        in_if.valid <= 1'b0;
        wait_drained();
        if (pending_results.size() != 0) begin
            report_mismatch("items never delivered", 8'(pending_results.size()), 8'h00);
        end
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== json_string_unescaper.f =====
src/jsu_pkg.sv
src/jsu_stream_if.sv
src/jsu_decode.sv
src/jsu_emit.sv
src/json_string_unescaper.sv
tb/tb_top.sv
